/* hdl/polygon_radial_expand_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the radial expand core
// Clocked on clock, held off during reset.
// ----------------------------------------------------------------------------
`ifndef POLYGON_RADIAL_EXPAND_CORE_DEFINES_SVH
`define POLYGON_RADIAL_EXPAND_CORE_DEFINES_SVH

// same-cycle implication
`define PRE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PRE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/pre_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_pkg
// Shared types and fixed widths of the radial expand core.
// ----------------------------------------------------------------------------
package pre_pkg;

   localparam int COORD_W = 16;
   localparam int CSR_W   = 17;
   localparam int SUM_W   = 23;
   localparam int CNT_W   = 7;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      last_point;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] moved_x;
      logic signed [COORD_W-1:0] moved_y;
      logic                      final_vertex;
      logic                      overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } vertex_type;

   typedef struct packed {
      logic                      bank;
      logic [CNT_W-1:0]          count;
      logic signed [SUM_W-1:0]   sum_x;
      logic signed [SUM_W-1:0]   sum_y;
      logic                      dropped;
   } job_type;

endpackage

/* hdl/pre_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_front
// Takes vertices, writes them to the current store bank, keeps running sums
// and hands a finished contour to the job queue.
// ----------------------------------------------------------------------------
module pre_front #(
   parameter int MAX_VERTICES = 64,
   parameter int IDX_W        = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  pre_pkg::req_type      req_data,
   output logic                  job_push,
   output pre_pkg::job_type      job_data,
   input  logic                  job_full,
   output logic                  mem_we,
   output logic [IDX_W:0]        mem_addr,
   output pre_pkg::vertex_type   mem_data
);

   logic                              bank_ff;
   logic [pre_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [pre_pkg::SUM_W-1:0]  sum_x_ff, sum_x_in;
   logic signed [pre_pkg::SUM_W-1:0]  sum_y_ff, sum_y_in;
   logic                              drop_ff, drop_in;
   logic                              accept;
   logic                              room;

   assign full   = job_full;
   assign accept = push && !job_full;
   assign room   = cnt_ff != pre_pkg::CNT_W'(MAX_VERTICES);

   assign mem_we     = accept && room;
   assign mem_addr   = {bank_ff, cnt_ff[IDX_W-1:0]};
   assign mem_data.x = req_data.point_x;
   assign mem_data.y = req_data.point_y;

   always_comb begin
      cnt_in   = cnt_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      drop_in  = drop_ff;
      if (room) begin
         cnt_in   = cnt_ff + 1'b1;
         sum_x_in = sum_x_ff + pre_pkg::SUM_W'(req_data.point_x);
         sum_y_in = sum_y_ff + pre_pkg::SUM_W'(req_data.point_y);
      end else begin
         drop_in = 1'b1;
      end
   end

   assign job_push         = accept && req_data.last_point;
   assign job_data.bank    = bank_ff;
   assign job_data.count   = cnt_in;
   assign job_data.sum_x   = sum_x_in;
   assign job_data.sum_y   = sum_y_in;
   assign job_data.dropped = drop_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         cnt_ff   <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         drop_ff  <= 1'b0;
      end else if (accept) begin
         if (req_data.last_point) begin
            // contour closed: start afresh in the other bank
            bank_ff  <= !bank_ff;
            cnt_ff   <= '0;
            sum_x_ff <= '0;
            sum_y_ff <= '0;
            drop_ff  <= 1'b0;
         end else begin
            cnt_ff   <= cnt_in;
            sum_x_ff <= sum_x_in;
            sum_y_ff <= sum_y_in;
            drop_ff  <= drop_in;
         end
      end
   end

endmodule

/* hdl/pre_job_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_job_fifo
// Two-entry queue of closed contours; the head stays until its run is done,
// so an entry also marks its store bank as busy.
// ----------------------------------------------------------------------------
module pre_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pre_pkg::job_type  push_data,
   output logic              full,
   input  logic              pop,
   output pre_pkg::job_type  head,
   output logic              empty
);

   pre_pkg::job_type  entry_ff [0:1];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;

   assign full  = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

/* hdl/pre_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pre_divider #(
   parameter int QW  = 41,
   parameter int DVW = 25
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [QW-1:0]   dividend,
   input  logic [DVW-1:0]  divisor,
   output logic            busy,
   output logic            done,
   output logic [QW-1:0]   quotient
);

   localparam int CW = $clog2(QW + 1);

   logic [QW-1:0]   q_ff, q_in;
   logic [DVW-1:0]  rem_ff, rem_in;
   logic [DVW-1:0]  dvs_ff;
   logic [CW-1:0]   cnt_ff;
   logic            busy_ff;
   logic            done_ff;
   logic [DVW:0]    rem_sh;
   logic [DVW:0]    rem_sub;
   logic            ge;

   assign rem_sh  = {rem_ff, q_ff[QW-1]};
   assign ge      = rem_sh >= {1'b0, dvs_ff};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};
   assign rem_in  = ge ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
   assign q_in    = {q_ff[QW-2:0], ge};

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(QW);
            q_ff    <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            q_ff   <= q_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

/* hdl/pre_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_isqrt
// Floor square root, one result bit per cycle (digit-by-digit method).
// ----------------------------------------------------------------------------
module pre_isqrt #(
   parameter int SW = 25
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [2*SW-1:0]   radicand,
   output logic              busy,
   output logic              done,
   output logic [SW-1:0]     root
);

   localparam int CW = $clog2(SW + 1);

   logic [2*SW-1:0]  rad_ff;
   logic [SW-1:0]    res_ff;
   logic [SW+1:0]    rem_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [SW+3:0]    rem_sh;
   logic [SW+3:0]    trial;
   logic [SW+3:0]    rem_sub;
   logic             ge;

   assign rem_sh  = {rem_ff, rad_ff[2*SW-1 -: 2]};
   assign trial   = {2'b00, res_ff, 2'b01};
   assign ge      = rem_sh >= trial;
   assign rem_sub = rem_sh - trial;

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(SW);
            rad_ff  <= radicand;
            res_ff  <= '0;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rad_ff <= {rad_ff[2*SW-3:0], 2'b00};
            res_ff <= {res_ff[SW-2:0], ge};
            rem_ff <= ge ? rem_sub[SW+1:0] : rem_sh[SW+1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

/* hdl/pre_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_back
// Holds the vertex store, forms the centroid of the head contour and moves
// each vertex along its ray, one vertex at a time, into the result register.
// ----------------------------------------------------------------------------
`include "polygon_radial_expand_core_defines.svh"

module pre_back #(
   parameter int FRAC_BITS    = 8,
   parameter int IDX_W        = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic signed [pre_pkg::CSR_W-1:0]    csr_data,
   input  logic                                mem_we,
   input  logic [IDX_W:0]                      mem_addr,
   input  pre_pkg::vertex_type                 mem_data,
   input  pre_pkg::job_type                    job_head,
   input  logic                                job_empty,
   output logic                                job_pop,
   output logic                                empty,
   input  logic                                pop,
   output pre_pkg::rsp_type                    rsp_data
);

   localparam int F     = FRAC_BITS;
   localparam int MAG_W = 16 + F;
   localparam int D_W   = 17 + F;
   localparam int SW    = 17 + F;
   localparam int QW    = 33 + F;
   localparam int T_W   = 18 + F;
   localparam int P_W   = T_W - F;
   localparam int V_W   = pre_pkg::CSR_W;
   localparam int SUM_W = pre_pkg::SUM_W;

   localparam logic signed [T_W-1:0] RND    = T_W'((1 << F) - 1);
   localparam logic signed [P_W-1:0] SAT_HI = P_W'(32767);
   localparam logic signed [P_W-1:0] SAT_LO = -P_W'(32768);

   typedef enum logic [3:0] {
      S_IDLE, S_CXD, S_CYD, S_READ, S_DIFF, S_SQR, S_ROOT, S_DIVX, S_DIVY, S_EMIT
   } state_type;

   state_type                   state_ff;
   pre_pkg::vertex_type         mem_ram [0:(2 << IDX_W)-1];
   pre_pkg::vertex_type         rd_data_ff;
   logic signed [V_W-1:0]       v_ff;
   logic [pre_pkg::CNT_W-1:0]   k_ff;
   logic signed [T_W-1:0]       cx_ff, cy_ff;
   logic signed [D_W-1:0]       dx_ff, dy_ff;
   logic [2*MAG_W-1:0]          sqx_ff, sqy_ff;
   logic signed [T_W-1:0]       qx_ff, qy_ff;
   logic                        div_start_ff;
   logic [QW-1:0]               div_dividend_ff;
   logic [SW-1:0]               div_divisor_ff;
   logic                        sq_start_ff;
   logic                        out_valid_ff;
   pre_pkg::rsp_type            out_data_ff;

   logic                        div_busy, div_done;
   logic [QW-1:0]               div_quot;
   logic                        sq_busy, sq_done;
   logic [SW-1:0]               sq_root;
   logic [2*SW-1:0]             radicand;
   logic signed [T_W-1:0]       px_ext, py_ext;
   logic signed [T_W-1:0]       dx_full, dy_full;
   logic [D_W-1:0]              neg_dx, neg_dy;
   logic [MAG_W-1:0]            ax, ay;
   logic [V_W-1:0]              neg_v, av;
   logic [QW-1:0]               prod_x, prod_y;
   logic [SUM_W-1:0]            neg_sx, neg_sy, asx, asy;
   logic signed [T_W-1:0]       quot_t, neg_quot;
   logic                        slot_free;
   logic                        last_k;
   logic                        rd_en;

   function automatic logic signed [15:0] land(input logic signed [15:0] p,
                                               input logic signed [T_W-1:0] q);
      logic signed [T_W-1:0] tot;
      logic signed [T_W-1:0] adj;
      logic signed [P_W-1:0] pix;
      tot = T_W'(p);
      tot = (tot <<< F) + q;
      // round toward zero before the shift
      adj = tot[T_W-1] ? tot + RND : tot;
      pix = adj[T_W-1:F];
      if (pix > SAT_HI) begin
         pix = SAT_HI;
      end else if (pix < SAT_LO) begin
         pix = SAT_LO;
      end
      return pix[15:0];
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (csr_valid) begin
         v_ff <= csr_data;
      end
   end

   // vertex store, two banks
   assign rd_en = state_ff == S_READ;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_addr] <= mem_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ram[{job_head.bank, k_ff[IDX_W-1:0]}];
      end
   end

   pre_divider #(.QW(QW), .DVW(SW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dividend_ff),
      .divisor  (div_divisor_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign radicand = (2*SW)'(sqx_ff) + (2*SW)'(sqy_ff);

   pre_isqrt #(.SW(SW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start_ff),
      .radicand (radicand),
      .busy     (sq_busy),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign px_ext  = T_W'(rd_data_ff.x);
   assign py_ext  = T_W'(rd_data_ff.y);
   assign dx_full = (px_ext <<< F) - cx_ff;
   assign dy_full = (py_ext <<< F) - cy_ff;

   assign neg_dx = -dx_ff;
   assign neg_dy = -dy_ff;
   assign ax     = dx_ff[D_W-1] ? neg_dx[MAG_W-1:0] : dx_ff[MAG_W-1:0];
   assign ay     = dy_ff[D_W-1] ? neg_dy[MAG_W-1:0] : dy_ff[MAG_W-1:0];
   assign neg_v  = -v_ff;
   assign av     = v_ff[V_W-1] ? neg_v : v_ff;

   // full-width magnitude products for the shift division
   assign prod_x = ax * av;
   assign prod_y = ay * av;

   assign neg_sx = -job_head.sum_x;
   assign neg_sy = -job_head.sum_y;
   assign asx    = job_head.sum_x[SUM_W-1] ? neg_sx : job_head.sum_x;
   assign asy    = job_head.sum_y[SUM_W-1] ? neg_sy : job_head.sum_y;

   assign quot_t   = div_quot[T_W-1:0];
   assign neg_quot = -quot_t;

   assign slot_free = !out_valid_ff || pop;
   assign last_k    = (k_ff + 1'b1) == job_head.count;
   assign job_pop   = state_ff == S_EMIT && slot_free && last_k;

   assign empty    = !out_valid_ff;
   assign rsp_data = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_start_ff <= 1'b0;
         sq_start_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         div_start_ff <= 1'b0;
         sq_start_ff  <= 1'b0;
         // a beat taken while emitting is replaced by the next one below
         if (pop && state_ff != S_EMIT) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (!job_empty) begin
                  div_start_ff    <= 1'b1;
                  div_dividend_ff <= QW'(asx) << F;
                  div_divisor_ff  <= SW'(job_head.count);
                  state_ff        <= S_CXD;
               end
            end
            S_CXD: begin
               if (div_done) begin
                  cx_ff           <= job_head.sum_x[SUM_W-1] ? neg_quot : quot_t;
                  div_start_ff    <= 1'b1;
                  div_dividend_ff <= QW'(asy) << F;
                  state_ff        <= S_CYD;
               end
            end
            S_CYD: begin
               if (div_done) begin
                  cy_ff    <= job_head.sum_y[SUM_W-1] ? neg_quot : quot_t;
                  k_ff     <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_DIFF;
            end
            S_DIFF: begin
               dx_ff    <= dx_full[D_W-1:0];
               dy_ff    <= dy_full[D_W-1:0];
               state_ff <= S_SQR;
            end
            S_SQR: begin
               sqx_ff      <= ax * ax;
               sqy_ff      <= ay * ay;
               sq_start_ff <= 1'b1;
               state_ff    <= S_ROOT;
            end
            S_ROOT: begin
               if (sq_done) begin
                  if (sq_root == '0) begin
                     // vertex on the centroid: pass through
                     qx_ff    <= '0;
                     qy_ff    <= '0;
                     state_ff <= S_EMIT;
                  end else begin
                     div_start_ff    <= 1'b1;
                     div_dividend_ff <= prod_x;
                     div_divisor_ff  <= sq_root;
                     state_ff        <= S_DIVX;
                  end
               end
            end
            S_DIVX: begin
               if (div_done) begin
                  qx_ff           <= (dx_ff[D_W-1] ^ v_ff[V_W-1]) ? neg_quot : quot_t;
                  div_start_ff    <= 1'b1;
                  div_dividend_ff <= prod_y;
                  state_ff        <= S_DIVY;
               end
            end
            S_DIVY: begin
               if (div_done) begin
                  qy_ff    <= (dy_ff[D_W-1] ^ v_ff[V_W-1]) ? neg_quot : quot_t;
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (slot_free) begin
                  out_valid_ff             <= 1'b1;
                  out_data_ff.moved_x      <= land(rd_data_ff.x, qx_ff);
                  out_data_ff.moved_y      <= land(rd_data_ff.y, qy_ff);
                  out_data_ff.final_vertex <= last_k;
                  out_data_ff.overflow     <= job_head.dropped;
                  k_ff                     <= k_ff + 1'b1;
                  state_ff                 <= last_k ? S_IDLE : S_READ;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `PRE_ASSERT_NOW(a_div_free, div_start_ff, !div_busy, "divider started while busy")
   `PRE_ASSERT_NOW(a_sqrt_free, sq_start_ff, !sq_busy, "square root started while busy")
   `PRE_ASSERT_NOW(a_read_in_job, rd_en, !job_empty && (k_ff < job_head.count), "read past contour")

endmodule

/* hdl/polygon_radial_expand_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_radial_expand_core
// Radial offset of a polygon contour about its vertex centroid.
//
//   channel   ports                          beat
//   input     push, full, req_data           one vertex
//   result    empty, pop, rsp_data           one moved vertex
//   control   csr_valid, csr_ready, csr_data offset distance
//
// A vertex is taken while a store bank is free; two contours
// can be held, one being filled while the other is worked off.
// Per contour the centroid takes two divisions; per vertex the square root
// and two divisions of the one shared divider, with the start, done and
// read steps, set the throughput.
// Reset is synchronous; the store needs no clearing pass.
// A stalled result holds the back end; the front end keeps taking vertices while a store bank is free.
// ----------------------------------------------------------------------------
module polygon_radial_expand_core #(
   parameter int MAX_VERTICES = 64,
   parameter int FRAC_BITS    = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  pre_pkg::req_type                   req_data,
   output logic                               empty,
   input  logic                               pop,
   output pre_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic signed [pre_pkg::CSR_W-1:0]   csr_data
);

   localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

   logic                  job_push;
   pre_pkg::job_type      job_data;
   logic                  job_full;
   logic                  job_pop;
   logic                  job_empty;
   pre_pkg::job_type      job_head;
   logic                  mem_we;
   logic [IDX_W:0]        mem_addr;
   pre_pkg::vertex_type   mem_data;

   pre_front #(.MAX_VERTICES(MAX_VERTICES), .IDX_W(IDX_W)) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .job_push (job_push),
      .job_data (job_data),
      .job_full (job_full),
      .mem_we   (mem_we),
      .mem_addr (mem_addr),
      .mem_data (mem_data)
   );

   pre_job_fifo u_jobs (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .full      (job_full),
      .pop       (job_pop),
      .head      (job_head),
      .empty     (job_empty)
   );

   pre_back #(
      .FRAC_BITS    (FRAC_BITS),
      .IDX_W        (IDX_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_data  (mem_data),
      .job_head  (job_head),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
